>>> rtl/ggm_pkg.sv
// shared types and constants for the greedy glob matcher
package ggm_pkg;

    // beat kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_SUBJECT = 2'd2,
        ACT_END     = 2'd3
    } action_t;

    // glob metacharacters
    localparam logic [7:0] SYM_ANY_ONE = 8'h3F;
    localparam logic [7:0] SYM_ANY_RUN = 8'h2A;

    localparam int SYMBOL_W = 8;

    // per-subject matching flags
    typedef struct packed {
        logic star_waiting;
        logic tail_accept;
        logic mismatch_seen;
    } match_flags_t;

endpackage

>>> rtl/ggm_ram.sv
// generic simple dual-read ram with registered read data
module ggm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr0,
    input  logic [$clog2(DEPTH)-1:0] rd_addr1,
    output logic [WIDTH-1:0]         rd_data0,
    output logic [WIDTH-1:0]         rd_data1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data0 <= mem_reg[rd_addr0];
        rd_data1 <= mem_reg[rd_addr1];
    end

endmodule

>>> rtl/ggm_step.sv
// next-state and verdict logic for one beat
module ggm_step import ggm_pkg::*; #(
    parameter int PATTERN_MAX = 64,
    parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
    input  action_t               action,
    input  logic [SYMBOL_W-1:0]   symbol,
    input  logic [LW-1:0]         pos,
    input  logic [LW-1:0]         len,
    input  match_flags_t          flags,
    input  logic                  ovf,
    input  logic [SYMBOL_W-1:0]   pat0,
    input  logic [SYMBOL_W-1:0]   pat1,
    output logic [LW-1:0]         pos_next,
    output logic [LW-1:0]         len_next,
    output match_flags_t          flags_next,
    output logic                  ovf_next,
    output logic                  wr_en,
    output logic                  matched
);

    localparam logic [LW:0] MAX_C = (LW + 1)'(PATTERN_MAX);

    logic [LW:0] pos_p1;
    logic [LW:0] len_x;

    assign pos_p1 = {1'b0, pos} + (LW + 1)'(1);
    assign len_x  = {1'b0, len};

    always_comb begin
        pos_next   = pos;
        len_next   = len;
        flags_next = flags;
        ovf_next   = ovf;
        wr_en      = 1'b0;
        matched    = 1'b0;
        unique case (action)
            ACT_CLEAR: begin
                len_next   = '0;
                ovf_next   = 1'b0;
                pos_next   = '0;
                flags_next = '0;
            end
            ACT_APPEND: begin
                if (len_x < MAX_C) begin
                    wr_en    = 1'b1;
                    len_next = LW'(len_x + (LW + 1)'(1));
                end else begin
                    ovf_next = 1'b1;
                end
                pos_next   = '0;
                flags_next = '0;
            end
            ACT_SUBJECT: begin
                if (!(flags.mismatch_seen || flags.tail_accept)) begin
                    if (flags.star_waiting) begin
                        // swallow until the byte after the star turns up
                        if (pos_p1 < len_x) begin
                            if (symbol == pat1) begin
                                pos_next                = LW'(pos_p1 + (LW + 1)'(1));
                                flags_next.star_waiting = 1'b0;
                            end
                        end else begin
                            flags_next.mismatch_seen = 1'b1;
                        end
                    end else if (pos >= len) begin
                        flags_next.mismatch_seen = 1'b1;
                    end else if (pat0 == SYM_ANY_ONE) begin
                        pos_next = LW'(pos_p1);
                    end else if (pat0 == SYM_ANY_RUN) begin
                        if (pos_p1 >= len_x) begin
                            // trailing star takes the rest
                            flags_next.tail_accept = 1'b1;
                            pos_next               = LW'(pos_p1);
                        end else if (symbol == pat1) begin
                            pos_next = LW'(pos_p1 + (LW + 1)'(1));
                        end else begin
                            flags_next.star_waiting = 1'b1;
                        end
                    end else if (pat0 == symbol) begin
                        pos_next = LW'(pos_p1);
                    end else begin
                        flags_next.mismatch_seen = 1'b1;
                    end
                end
            end
            ACT_END: begin
                // verdict, then back to the start of the pattern
                if (flags.tail_accept) begin
                    matched = 1'b1;
                end else if (flags.mismatch_seen || flags.star_waiting) begin
                    matched = 1'b0;
                end else begin
                    matched = (pos >= len);
                end
                if (ovf) begin
                    matched = 1'b0;
                end
                pos_next   = '0;
                flags_next = '0;
            end
            default: begin
                pos_next = pos;
            end
        endcase
    end

endmodule

>>> rtl/greedy_glob_matcher.sv
// greedy glob matcher: input register, pattern ram, step logic, result register
// throughput: one beat per cycle unless an end beat waits on a stalled result,
// set by the single pass through the step logic with pattern bytes at the position
// and the next one read ahead from the ram
// reset: synchronous active-low aresetn clears pattern length, matching state and valids
// pattern ram contents stay undefined until written; no clearing pass
module greedy_glob_matcher import ggm_pkg::*; #(
    parameter int PATTERN_MAX = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [1:0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int AW = $clog2(PATTERN_MAX);

    // input register
    logic                in_valid_reg, in_valid_next;
    action_t             in_action_reg;
    logic [SYMBOL_W-1:0] in_symbol_reg;

    // matching state
    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] len_reg, len_next;
    match_flags_t  flags_reg, flags_next;
    logic          ovf_reg, ovf_next;

    // result register
    logic out_valid_reg, out_valid_next;
    logic out_matched_reg;
    logic out_ovf_reg;

    // ram bypass for a write hitting a read address
    logic                byp0_reg, byp1_reg;
    logic [SYMBOL_W-1:0] byp_data_reg;

    logic [LW-1:0]       st_pos, st_len;
    match_flags_t        st_flags;
    logic                st_ovf, st_wr_en, st_matched;
    logic                advance, wr_en;
    logic [AW-1:0]       wr_addr, rd_addr0, rd_addr1;
    logic [SYMBOL_W-1:0] ram_q0, ram_q1, pat0, pat1;

    // beat in the input register moves on unless its result has nowhere to go
    assign advance  = in_valid_reg &&
                      (in_action_reg != ACT_END || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign pat0 = byp0_reg ? byp_data_reg : ram_q0;
    assign pat1 = byp1_reg ? byp_data_reg : ram_q1;

    ggm_step #(
        .PATTERN_MAX (PATTERN_MAX),
        .LW          (LW)
    ) u_step (
        .action     (in_action_reg),
        .symbol     (in_symbol_reg),
        .pos        (pos_reg),
        .len        (len_reg),
        .flags      (flags_reg),
        .ovf        (ovf_reg),
        .pat0       (pat0),
        .pat1       (pat1),
        .pos_next   (st_pos),
        .len_next   (st_len),
        .flags_next (st_flags),
        .ovf_next   (st_ovf),
        .wr_en      (st_wr_en),
        .matched    (st_matched)
    );

    // state next values, held while nothing advances
    always_comb begin
        pos_next   = advance ? st_pos   : pos_reg;
        len_next   = advance ? st_len   : len_reg;
        flags_next = advance ? st_flags : flags_reg;
        ovf_next   = advance ? st_ovf   : ovf_reg;
    end

    // read ahead at the position the next beat will see
    assign wr_en    = advance && st_wr_en;
    assign wr_addr  = len_reg[AW-1:0];
    assign rd_addr0 = pos_next[AW-1:0];
    assign rd_addr1 = AW'(pos_next + LW'(1));

    ggm_ram #(
        .WIDTH (SYMBOL_W),
        .DEPTH (PATTERN_MAX)
    ) u_ram (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (in_symbol_reg),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (ram_q0),
        .rd_data1 (ram_q1)
    );

    // valid next values for the two register stages
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance && in_action_reg == ACT_END) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
            flags_reg     <= '0;
            ovf_reg       <= 1'b0;
            byp0_reg      <= 1'b0;
            byp1_reg      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            flags_reg     <= flags_next;
            ovf_reg       <= ovf_next;
            byp0_reg      <= wr_en && (wr_addr == rd_addr0);
            byp1_reg      <= wr_en && (wr_addr == rd_addr1);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_symbol_reg <= s_tdata;
        end
        if (advance && in_action_reg == ACT_END) begin
            out_matched_reg <= st_matched;
            out_ovf_reg     <= ovf_reg;
        end
        byp_data_reg <= in_symbol_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_ovf_reg, out_matched_reg};

endmodule

>>> rtl/ggm_checker.sv
// port-level checks for the greedy glob matcher, bound to the top level
module ggm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // result beat holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // with the result side empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

    // reset empties the result stage
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a match is never reported alongside an overflowed pattern
    a_no_match_on_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("match reported with pattern overflow");

endmodule

bind greedy_glob_matcher ggm_checker u_ggm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
